[sv/tsp_pkg.sv]
`default_nettype none

package tsp_pkg;

    localparam int FREQ_W       = 11;
    localparam int DUR_W        = 9;
    localparam int TONE_W       = FREQ_W + DUR_W;
    localparam int COUNT_W      = 3;
    localparam int MAX_TONES    = 4;
    localparam int SLOT_W       = 2;
    localparam int VOLUME_W     = 8;
    localparam int SOUND_W      = 3;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [DUR_W-1:0]    ELAPSED_MAX  = 9'd511;
    localparam logic [VOLUME_W-1:0] VOLUME_RESET = 8'd128;

    typedef enum logic {
        ACT_TICK = 1'b0,
        ACT_PLAY = 1'b1
    } t_action;

    typedef enum logic {
        CFG_VOLUME        = 1'b0,
        CFG_SOUND_ENABLED = 1'b1
    } t_cfg_reg;

    localparam logic [SOUND_W-1:0] SND_WORK_END   = 3'd0;
    localparam logic [SOUND_W-1:0] SND_BREAK_END  = 3'd1;
    localparam logic [SOUND_W-1:0] SND_CHIME      = 3'd2;
    localparam logic [SOUND_W-1:0] SND_MODE       = 3'd3;
    localparam logic [SOUND_W-1:0] SND_RESET      = 3'd4;
    localparam logic [SOUND_W-1:0] SND_TICK       = 3'd5;
    localparam logic [SOUND_W-1:0] SND_FINAL_BEEP = 3'd6;

    typedef logic [TONE_W-1:0] t_tone;

    function automatic t_tone mk_tone(input logic [FREQ_W-1:0] freq,
                                      input logic [DUR_W-1:0] dur);
        return {freq, dur};
    endfunction

    // number of tones in a preset; unknown codes play the short tick
    function automatic logic [COUNT_W-1:0] preset_count(input logic [SOUND_W-1:0] snd);
        logic [COUNT_W-1:0] n;
        case (snd)
            SND_WORK_END:   n = 3'd4;
            SND_BREAK_END:  n = 3'd4;
            SND_CHIME:      n = 3'd3;
            SND_MODE:       n = 3'd1;
            SND_RESET:      n = 3'd2;
            SND_TICK:       n = 3'd1;
            SND_FINAL_BEEP: n = 3'd2;
            default:        n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic t_tone preset_tone(input logic [SOUND_W-1:0] snd,
                                          input logic [SLOT_W-1:0] slot);
        t_tone t;
        t = '0;
        case (snd)
            SND_WORK_END: begin
                case (slot)
                    2'd0:    t = mk_tone(11'd523, 9'd120);
                    2'd1:    t = mk_tone(11'd659, 9'd120);
                    2'd2:    t = mk_tone(11'd784, 9'd120);
                    default: t = mk_tone(11'd1047, 9'd350);
                endcase
            end
            SND_BREAK_END: begin
                case (slot)
                    2'd0:    t = mk_tone(11'd784, 9'd150);
                    2'd1:    t = mk_tone(11'd659, 9'd150);
                    2'd2:    t = mk_tone(11'd523, 9'd150);
                    default: t = mk_tone(11'd392, 9'd300);
                endcase
            end
            SND_CHIME: begin
                case (slot)
                    2'd0:    t = mk_tone(11'd659, 9'd100);
                    2'd1:    t = mk_tone(11'd784, 9'd120);
                    2'd2:    t = mk_tone(11'd988, 9'd180);
                    default: t = '0;
                endcase
            end
            SND_MODE: begin
                t = (slot == 2'd0) ? mk_tone(11'd587, 9'd60) : '0;
            end
            SND_RESET: begin
                t = (slot == 2'd0 || slot == 2'd1) ? mk_tone(11'd523, 9'd80) : '0;
            end
            SND_FINAL_BEEP: begin
                case (slot)
                    2'd0:    t = mk_tone(11'd880, 9'd100);
                    2'd1:    t = mk_tone(11'd880, 9'd200);
                    default: t = '0;
                endcase
            end
            default: begin
                t = (slot == 2'd0) ? mk_tone(11'd880, 9'd50) : '0;
            end
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

[sv/tone_sequence_player.sv]
// The result of a transaction is in the output register
//   on the edge after it is accepted.
// Throughput: one transaction per cycle while o_stall is low; the state update and the result both
//   come from the one state register set, with the output register as a skid.
// Reset (synchronous, active low): idle, volume 128, sound disabled; the tone
//   queue is not cleared and is only read after a sequence has written it.
`default_nettype none

module tone_sequence_player
    import tsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,

    // configuration write port
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_index,
    input  wire logic [VOLUME_W-1:0] i_cfg_data,

    // request/tick channel
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic                i_action,
    input  wire logic [SOUND_W-1:0]  i_sound,

    // result channel
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic                     o_playing,
    output logic [FREQ_W-1:0]        o_frequency_hz,
    output logic [VOLUME_W-1:0]      o_duty,
    output logic                     o_request_taken
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    // common width for index/count comparisons
    localparam int CMP_W = (IDX_W + 1 > COUNT_W) ? IDX_W + 1 : COUNT_W;

    // configuration
    logic [VOLUME_W-1:0] r_volume;
    logic                r_sound_en;

    // sequencer state
    t_tone               r_queue [QUEUE_DEPTH];
    t_tone               r_cur;     // copy of the sounding queue entry
    logic [IDX_W-1:0]    r_index;
    logic [COUNT_W-1:0]  r_count;
    logic [DUR_W-1:0]    r_elapsed;
    logic                r_active;

    // result register
    logic                r_out_valid;
    logic                r_playing;
    logic [FREQ_W-1:0]   r_freq;
    logic [VOLUME_W-1:0] r_duty;
    logic                r_taken;

    logic                accept;
    logic                play_ok;
    logic                advance;
    logic                seq_done;
    logic [COUNT_W-1:0]  preset_n;
    logic [CMP_W-1:0]    idx_inc;
    logic [DUR_W-1:0]    elapsed_inc;

    logic [IDX_W-1:0]    n_index;
    logic [COUNT_W-1:0]  n_count;
    logic [DUR_W-1:0]    n_elapsed;
    logic                n_active;
    t_tone               n_cur;

    // Output register doubles as the skid stage: take a new transaction
    // whenever the held result is empty or leaving this cycle.
    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    assign preset_n = preset_count(i_sound);
    assign play_ok  = (t_action'(i_action) == ACT_PLAY) && !r_active && r_sound_en
                      && (CMP_W'(preset_n) <= CMP_W'(QUEUE_DEPTH));

    // elapsed count saturates at its top value
    assign elapsed_inc = (r_elapsed < ELAPSED_MAX) ? r_elapsed + 1'b1 : r_elapsed;
    assign advance     = (t_action'(i_action) == ACT_TICK) && r_active
                         && (elapsed_inc >= r_cur[DUR_W-1:0]);
    assign idx_inc     = CMP_W'(r_index) + 1'b1;
    assign seq_done    = (idx_inc >= CMP_W'(r_count)) || (idx_inc >= CMP_W'(QUEUE_DEPTH));

    always_comb begin
        n_index   = r_index;
        n_count   = r_count;
        n_elapsed = r_elapsed;
        n_active  = r_active;
        n_cur     = r_cur;
        if (play_ok) begin
            n_index   = '0;
            n_count   = preset_n;
            n_elapsed = '0;
            n_active  = 1'b1;
            n_cur     = preset_tone(i_sound, '0);
        end else if ((t_action'(i_action) == ACT_TICK) && r_active) begin
            n_elapsed = elapsed_inc;
            if (advance) begin
                n_elapsed = '0;
                if (seq_done) begin
                    n_active = 1'b0;
                    n_index  = '0;
                    n_count  = '0;
                end else begin
                    // next entry lies inside the queue when not done
                    n_index = idx_inc[IDX_W-1:0];
                    n_cur   = r_queue[idx_inc[IDX_W-1:0]];
                end
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume   <= VOLUME_RESET;
            r_sound_en <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_VOLUME:        r_volume   <= i_cfg_data;
                CFG_SOUND_ENABLED: r_sound_en <= i_cfg_data[0];
                default:           ;
            endcase
        end
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index   <= '0;
            r_count   <= '0;
            r_elapsed <= '0;
            r_active  <= 1'b0;
        end else if (accept) begin
            r_index   <= n_index;
            r_count   <= n_count;
            r_elapsed <= n_elapsed;
            r_active  <= n_active;
        end
    end

    // tone queue: a taken request loads every preset slot that fits
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur <= n_cur;
            if (play_ok) begin
                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                    if (i < MAX_TONES) begin
                        r_queue[i] <= preset_tone(i_sound, SLOT_W'(i));
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_playing <= n_active;
            r_freq    <= n_active ? n_cur[TONE_W-1:DUR_W] : '0;
            r_duty    <= n_active ? r_volume : '0;
            r_taken   <= play_ok;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_playing       = r_playing;
    assign o_frequency_hz  = r_freq;
    assign o_duty          = r_duty;
    assign o_request_taken = r_taken;

endmodule

`default_nettype wire
